// File: sv/sstq_pkg.sv
package sstq_pkg;

  localparam int TID_W            = 6;
  localparam int DUR_W            = 32;
  localparam int TICK_W           = 64;
  localparam int DEF_QUEUE_DEPTH  = 16;
  localparam int DEF_THREAD_COUNT = 64;
  localparam int MAX_WAKES        = 16;
  localparam int WAKE_CNT_W       = $clog2(MAX_WAKES + 1);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SLEEP  = 2'd1,
    OP_CANCEL = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_QUEUED       = 3'd0,
    ST_ZERO         = 3'd1,
    ST_ALREADY      = 3'd2,
    ST_FULL         = 3'd3,
    ST_CANCELLED    = 3'd4,
    ST_NOT_SLEEPING = 3'd5,
    ST_WOKEN        = 3'd6
  } status_t;

  // one queue slot: thread id and absolute wake tick
  typedef struct packed {
    logic [TID_W-1:0]  tid;
    logic [TICK_W-1:0] wake;
  } entry_t;

endpackage

// File: sv/sstq_in_if.sv
interface sstq_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [sstq_pkg::TID_W-1:0] thread_id;
  logic [sstq_pkg::DUR_W-1:0] duration;

  modport source (output valid, operation, thread_id, duration, input ready);
  modport sink (input valid, operation, thread_id, duration, output ready);
endinterface

// File: sv/sstq_out_if.sv
interface sstq_out_if;
  logic                       valid;
  logic                       ready;
  logic [sstq_pkg::TID_W-1:0] thread_id_out;
  logic [2:0]                 status;
  logic                       last;

  modport source (output valid, thread_id_out, status, last, input ready);
  modport sink (input valid, thread_id_out, status, last, output ready);
endinterface

// File: sv/sorted_sleep_timer_queue.sv
// channel  | dir | handshake       | payload
// in_ch    | in  | valid / ready   | operation, thread_id, duration
// out_ch   | out | valid / ready   | thread_id_out, status, last
//
// structure: a ram with registered read and one shared 64-bit compare; a search step is a
//   read then a check; a tick wakes due threads from the head, up to MAX_WAKES per tick;
//   a sleep moves later entries up from the tail; a cancel walks every queued entry from
//   the head; a refused sleep, or a cancel of a thread not sleeping, only responds
// reset: synchronous rst_n clears tick counter, fill, head and sleeping flags, not the ram
// stalls: in_ch is taken only in idle; a sequence holds only while it has a result to place
module sorted_sleep_timer_queue #(
  parameter int QUEUE_DEPTH  = sstq_pkg::DEF_QUEUE_DEPTH,
  parameter int THREAD_COUNT = sstq_pkg::DEF_THREAD_COUNT
) (
  input  logic       clk,
  input  logic       rst_n,
  sstq_in_if.sink    in_ch,
  sstq_out_if.source out_ch
);

  localparam int AW     = $clog2(QUEUE_DEPTH);        // ram address
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);    // fill count and logical index
  localparam int SUM_W  = CNT_W + 1;
  localparam int IDX_W  = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int TICK_W = sstq_pkg::TICK_W;
  localparam int TID_W  = sstq_pkg::TID_W;
  localparam int KW     = sstq_pkg::WAKE_CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_RD,
    S_TICK_CHK,
    S_INS_RD,
    S_INS_CHK,
    S_CAN_RD,
    S_CAN_CHK,
    S_RESP
  } state_t;

  state_t                  state_r, state_nxt;
  logic [TICK_W-1:0]       tick_r, tick_nxt;
  logic [AW-1:0]           head_r, head_nxt;       // physical slot of queue position 0
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;         // logical scan position
  logic [KW-1:0]           k_r, k_nxt;             // wakes issued this tick
  logic                    pend_r, pend_nxt;       // a woken thread waits for its last flag
  logic [TID_W-1:0]        pend_tid_r, pend_tid_nxt;
  logic [TID_W-1:0]        tid_r, tid_nxt;
  logic [TICK_W-1:0]       wake_r, wake_nxt;
  sstq_pkg::status_t       st_r, st_nxt;
  logic                    found_r, found_nxt;
  logic [THREAD_COUNT-1:0] sleeping_r, sleeping_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [TID_W-1:0]        out_tid_r, out_tid_nxt;
  sstq_pkg::status_t       out_st_r, out_st_nxt;
  logic                    out_last_r, out_last_nxt;

  // ram ports
  logic             wr_en, rd_en;
  logic [AW-1:0]    slot_addr;
  sstq_pkg::entry_t wr_data, rd_data;

  logic [CNT_W-1:0] log_idx;
  logic [SUM_W-1:0] slot_sum;
  logic [TICK_W-1:0] cmp_ref;
  logic             cmp_le;
  logic             out_free;
  logic             in_tid_ok, rd_tid_ok, due;
  logic [IDX_W-1:0] in_tidx, rd_tidx;
  sstq_pkg::entry_t new_entry;

  sstq_ram #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (slot_addr),
    .rd_data (rd_data)
  );

  // logical queue position to ram slot, circular from the head
  always_comb begin
    slot_sum = SUM_W'(head_r) + SUM_W'(log_idx);
    if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
    end
    slot_addr = AW'(slot_sum);
  end

  // the one shared compare: head against the counter, or an entry against the new wake tick
  assign cmp_ref = (state_r == S_TICK_CHK) ? tick_r : wake_r;
  assign cmp_le  = rd_data.wake <= cmp_ref;

  assign in_tid_ok = 32'(in_ch.thread_id) < 32'(THREAD_COUNT);
  assign rd_tid_ok = 32'(rd_data.tid) < 32'(THREAD_COUNT);
  assign in_tidx   = IDX_W'(in_ch.thread_id);
  assign rd_tidx   = IDX_W'(rd_data.tid);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign due       = (count_r != '0) && cmp_le && (k_r < KW'(sstq_pkg::MAX_WAKES));
  assign new_entry = '{tid: tid_r, wake: wake_r};

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.thread_id_out = out_tid_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.last          = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    pend_tid_nxt  = pend_tid_r;
    tid_nxt       = tid_r;
    wake_nxt      = wake_r;
    st_nxt        = st_r;
    found_nxt     = found_r;
    sleeping_nxt  = sleeping_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_tid_nxt   = out_tid_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    wr_data       = rd_data;
    log_idx       = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          tid_nxt = in_ch.thread_id;
          unique case (sstq_pkg::op_t'(in_ch.operation))
            sstq_pkg::OP_TICK: begin
              tick_nxt = tick_r + 1'b1;
              k_nxt    = '0;
              pend_nxt = 1'b0;
              if (count_r != '0) begin
                state_nxt = S_TICK_RD;
              end
            end
            sstq_pkg::OP_SLEEP: begin
              wake_nxt  = tick_r + TICK_W'(in_ch.duration);
              idx_nxt   = count_r;
              state_nxt = S_RESP;
              if (in_ch.duration == '0) begin
                st_nxt = sstq_pkg::ST_ZERO;
              end else if (!in_tid_ok) begin
                st_nxt = sstq_pkg::ST_FULL;
              end else if (sleeping_r[in_tidx]) begin
                st_nxt = sstq_pkg::ST_ALREADY;
              end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                st_nxt = sstq_pkg::ST_FULL;
              end else begin
                st_nxt                = sstq_pkg::ST_QUEUED;
                sleeping_nxt[in_tidx] = 1'b1;
                count_nxt             = count_r + 1'b1;
                state_nxt             = S_INS_RD;
              end
            end
            sstq_pkg::OP_CANCEL: begin
              idx_nxt   = '0;
              found_nxt = 1'b0;
              if (in_tid_ok && sleeping_r[in_tidx]) begin
                sleeping_nxt[in_tidx] = 1'b0;
                st_nxt                = sstq_pkg::ST_CANCELLED;
                state_nxt             = S_CAN_RD;
              end else begin
                st_nxt    = sstq_pkg::ST_NOT_SLEEPING;
                state_nxt = S_RESP;
              end
            end
            default: ;  // unused code: dropped
          endcase
        end
      end

      // tick: look at the head, wake it if due; a woken thread is held until
      // the next head check so its last flag is known when it goes out
      S_TICK_RD: begin
        log_idx   = '0;
        rd_en     = 1'b1;
        state_nxt = S_TICK_CHK;
      end

      S_TICK_CHK: begin
        log_idx = '0;
        if (!pend_r || out_free) begin
          if (pend_r) begin
            out_valid_nxt = 1'b1;
            out_tid_nxt   = pend_tid_r;
            out_st_nxt    = sstq_pkg::ST_WOKEN;
            out_last_nxt  = !due;
          end
          if (due) begin
            pend_nxt     = 1'b1;
            pend_tid_nxt = rd_data.tid;
            if (rd_tid_ok) begin
              sleeping_nxt[rd_tidx] = 1'b0;
            end
            head_nxt  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            count_nxt = count_r - 1'b1;
            k_nxt     = k_r + 1'b1;
            state_nxt = S_TICK_RD;
          end else begin
            pend_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end

      // sleep: walk from the tail toward the head, moving later entries up one slot
      S_INS_RD: begin
        if (idx_r == '0) begin
          log_idx   = '0;
          wr_en     = 1'b1;
          wr_data   = new_entry;
          state_nxt = S_RESP;
        end else begin
          log_idx   = idx_r - 1'b1;
          rd_en     = 1'b1;
          state_nxt = S_INS_CHK;
        end
      end

      S_INS_CHK: begin
        log_idx = idx_r;
        wr_en   = 1'b1;
        if (cmp_le) begin
          wr_data   = new_entry;
          state_nxt = S_RESP;
        end else begin
          wr_data   = rd_data;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_INS_RD;
        end
      end

      // cancel: walk from the head; once the thread is seen, pull later entries down
      S_CAN_RD: begin
        log_idx   = idx_r;
        rd_en     = 1'b1;
        state_nxt = S_CAN_CHK;
      end

      S_CAN_CHK: begin
        log_idx = idx_r - 1'b1;
        if (found_r) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
        end else if (rd_data.tid == tid_r) begin
          found_nxt = 1'b1;
        end
        if (idx_r == count_r - 1'b1) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_RESP;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_CAN_RD;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tid_nxt   = tid_r;
          out_st_nxt    = st_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      sleeping_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      sleeping_r  <= sleeping_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    pend_tid_r <= pend_tid_nxt;
    tid_r      <= tid_nxt;
    wake_r     <= wake_nxt;
    st_r       <= st_nxt;
    found_r    <= found_nxt;
    out_tid_r  <= out_tid_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// File: sv/sstq_ram.sv
module sstq_ram #(
  parameter int DEPTH = sstq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  sstq_pkg::entry_t         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output sstq_pkg::entry_t         rd_data
);

  sstq_pkg::entry_t mem [DEPTH];
  sstq_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
